// ===== hdl/uche_pkg.sv =====
// shared types and constants of the hex escape encoder
package uche_pkg;

    // default width of the per-string output byte counter
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // reset value and width of the output capacity register
    localparam int              CAP_WIDTH = 16;
    localparam logic [15:0]     CAP_RESET = 16'hffff;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_OVF = 2'd2;

    // escape prefix characters
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_X         = 8'h78;

    // four-byte scan window: held bytes plus the new byte
    typedef logic [3:0][7:0] win_t;

    // what to do with the byte at the scan position
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_COPY_SEQ,
        ACT_COPY_ONE,
        ACT_ESCAPE
    } act_t;

    // decision of the byte classifier
    typedef struct packed {
        act_t       act;
        logic [2:0] need;
        logic [2:0] avail;
    } decision_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_FLUSH,
        ST_END
    } state_t;

endpackage

// ===== hdl/uche_intf.sv =====
// channel interfaces of the hex escape encoder

// input byte channel
interface uche_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// result channel
interface uche_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_run;

    modport source (output valid, output out_byte, output out_kind, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input out_kind, input last_of_run,
                    output ready);
endinterface

// capacity register write channel
interface uche_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] output_capacity;

    modport source (output valid, output output_capacity, input ready);
    modport sink   (input valid, input output_capacity, output ready);
endinterface

// ===== hdl/unsafe_char_hex_escaper_unit.sv =====
// top level of the utf-8 checking hex escape encoder
//
// Takes one string byte per transaction; a zero byte ends the string and gives one end
// result (kind 1, or kind 2 when the output capacity was exceeded). Bytes of an
// unfinished utf-8 sequence are held (up to three) and give no result until the
// sequence is decided. Steps: the byte is taken in the idle state, then a single shared
// classifier decides the scan positions one at a time in the scan state, each output
// byte is staged in the emit state, a last scan finds the window done, and the flush
// state hands the last data byte to the result register. Output stalls hold the
// sequencer. There is no clearing pass after reset. The capacity register is written
// through its own channel, which is always ready.
module unsafe_char_hex_escaper_unit
#(
    parameter int COUNT_WIDTH = uche_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    uche_in_if.sink    chars,
    uche_out_if.source results,
    uche_cfg_if.sink   cap_wr
);

    localparam int RW = (COUNT_WIDTH > uche_pkg::CAP_WIDTH) ? COUNT_WIDTH
                                                            : uche_pkg::CAP_WIDTH;

    // control registers
    uche_pkg::state_t       st_reg, st_next;
    logic [2:0]             wn_reg, wn_next;
    logic [2:0]             pos_reg, pos_next;
    logic                   at_end_reg, at_end_next;
    logic [1:0]             held_reg, held_next;
    logic                   ovf_reg, ovf_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [15:0]            cap_reg, cap_next;
    logic                   stage_valid_reg, stage_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             k_reg, k_next;

    // payload registers
    uche_pkg::win_t         win_reg, win_next;
    logic [7:0]             stage_byte_reg, stage_byte_next;
    logic [1:0]             unit_pos_reg, unit_pos_next;
    logic [2:0]             unit_len_reg, unit_len_next;
    logic                   unit_esc_reg, unit_esc_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;

    // shared conditions
    logic                   accept;
    logic                   byte_zero;
    logic                   can_push;
    logic                   scan_done;
    logic                   no_fit;
    logic                   unit_last;
    logic [RW-1:0]          room;
    logic [7:0]             emit_byte;
    uche_pkg::decision_t    dec;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        else
            return 8'h57 + 8'(n);
    endfunction

    // channel ports
    assign chars.ready         = (st_reg == uche_pkg::ST_IDLE);
    assign cap_wr.ready        = 1'b1;
    assign results.valid       = out_valid_reg;
    assign results.out_byte    = out_byte_reg;
    assign results.out_kind    = out_kind_reg;
    assign results.last_of_run = out_last_reg;

    assign accept    = chars.valid && chars.ready;
    assign byte_zero = (chars.in_byte == 8'd0);
    assign can_push  = !out_valid_reg || results.ready;
    assign scan_done = (pos_reg >= wn_reg);

    // free output room, zero when capacity is below the count
    always_comb
    begin
        if (RW'(cap_reg) > RW'(count_reg))
            room = RW'(cap_reg) - RW'(count_reg);
        else
            room = '0;
    end

    assign no_fit = room < RW'(dec.need);

    // shared classifier at the scan position
    uche_classify u_classify
    (
        .win    (win_reg),
        .wn     (wn_reg),
        .pos    (pos_reg[1:0]),
        .at_end (at_end_reg),
        .dec    (dec)
    );

    // byte of the unit being emitted
    always_comb
    begin
        if (unit_esc_reg)
        begin
            case (k_reg)
                2'd0:    emit_byte = uche_pkg::CHAR_BACKSLASH;
                2'd1:    emit_byte = uche_pkg::CHAR_X;
                2'd2:    emit_byte = hex_char(win_reg[unit_pos_reg][7:4]);
                default: emit_byte = hex_char(win_reg[unit_pos_reg][3:0]);
            endcase
        end
        else
        begin
            emit_byte = win_reg[2'(unit_pos_reg + k_reg)];
        end
    end

    assign unit_last = unit_esc_reg ? (k_reg == 2'd3) : (k_reg == 2'(unit_len_reg - 3'd1));

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            uche_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!ovf_reg)
                        st_next = uche_pkg::ST_SCAN;
                    else if (byte_zero)
                        st_next = uche_pkg::ST_END;
                end
            end
            uche_pkg::ST_SCAN:
            begin
                if (scan_done || dec.act == uche_pkg::ACT_HOLD || no_fit)
                begin
                    if (stage_valid_reg)
                        st_next = uche_pkg::ST_FLUSH;
                    else if (at_end_reg)
                        st_next = uche_pkg::ST_END;
                    else
                        st_next = uche_pkg::ST_IDLE;
                end
                else
                begin
                    st_next = uche_pkg::ST_EMIT;
                end
            end
            uche_pkg::ST_EMIT:
            begin
                if ((!stage_valid_reg || can_push) && unit_last)
                    st_next = uche_pkg::ST_SCAN;
            end
            uche_pkg::ST_FLUSH:
            begin
                if (can_push)
                    st_next = at_end_reg ? uche_pkg::ST_END : uche_pkg::ST_IDLE;
            end
            uche_pkg::ST_END:
            begin
                if (can_push)
                    st_next = uche_pkg::ST_IDLE;
            end
            default:
            begin
                st_next = uche_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        wn_next          = wn_reg;
        pos_next         = pos_reg;
        at_end_next      = at_end_reg;
        held_next        = held_reg;
        ovf_next         = ovf_reg;
        count_next       = count_reg;
        cap_next         = cap_reg;
        stage_valid_next = stage_valid_reg;
        k_next           = k_reg;
        win_next         = win_reg;
        stage_byte_next  = stage_byte_reg;
        unit_pos_next    = unit_pos_reg;
        unit_len_next    = unit_len_reg;
        unit_esc_next    = unit_esc_reg;
        out_valid_next   = out_valid_reg && !results.ready;
        out_byte_next    = out_byte_reg;
        out_kind_next    = out_kind_reg;
        out_last_next    = out_last_reg;

        // capacity register write
        if (cap_wr.valid)
            cap_next = cap_wr.output_capacity;

        case (st_reg)
            uche_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next    = '0;
                    at_end_next = byte_zero;
                    if (byte_zero)
                    begin
                        wn_next = {1'b0, held_reg};
                    end
                    else
                    begin
                        win_next[held_reg] = chars.in_byte;
                        wn_next            = 3'({1'b0, held_reg} + 3'd1);
                    end
                end
            end
            uche_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    held_next = '0;
                    if (at_end_reg && room == '0)
                        ovf_next = 1'b1;
                end
                else if (dec.act == uche_pkg::ACT_HOLD)
                begin
                    // keep the unfinished sequence at the window start
                    for (int k = 0; k < 3; k++)
                        win_next[k] = win_reg[2'(pos_reg[1:0] + 2'(k))];
                    held_next = dec.avail[1:0];
                end
                else if (no_fit)
                begin
                    ovf_next  = 1'b1;
                    held_next = '0;
                end
                else
                begin
                    count_next    = COUNT_WIDTH'(count_reg + COUNT_WIDTH'(dec.need));
                    unit_pos_next = pos_reg[1:0];
                    unit_len_next = dec.need;
                    unit_esc_next = (dec.act == uche_pkg::ACT_ESCAPE);
                    k_next        = '0;
                end
            end
            uche_pkg::ST_EMIT:
            begin
                if (!stage_valid_reg || can_push)
                begin
                    // older staged byte is known not to be the last one
                    if (stage_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = stage_byte_reg;
                        out_kind_next  = uche_pkg::KIND_DATA;
                        out_last_next  = 1'b0;
                    end
                    stage_valid_next = 1'b1;
                    stage_byte_next  = emit_byte;
                    if (unit_last)
                        pos_next = 3'(pos_reg + (unit_esc_reg ? 3'd1 : unit_len_reg));
                    else
                        k_next = 2'(k_reg + 2'd1);
                end
            end
            uche_pkg::ST_FLUSH:
            begin
                if (can_push)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = stage_byte_reg;
                    out_kind_next    = uche_pkg::KIND_DATA;
                    out_last_next    = !at_end_reg;
                    stage_valid_next = 1'b0;
                end
            end
            uche_pkg::ST_END:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    out_kind_next  = ovf_reg ? uche_pkg::KIND_END_OVF : uche_pkg::KIND_END_OK;
                    out_last_next  = 1'b1;
                    held_next      = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
                held_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= uche_pkg::ST_IDLE;
            wn_reg          <= '0;
            pos_reg         <= '0;
            at_end_reg      <= 1'b0;
            held_reg        <= '0;
            ovf_reg         <= 1'b0;
            count_reg       <= '0;
            cap_reg         <= uche_pkg::CAP_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            k_reg           <= '0;
        end
        else
        begin
            st_reg          <= st_next;
            wn_reg          <= wn_next;
            pos_reg         <= pos_next;
            at_end_reg      <= at_end_next;
            held_reg        <= held_next;
            ovf_reg         <= ovf_next;
            count_reg       <= count_next;
            cap_reg         <= cap_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            k_reg           <= k_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        win_reg        <= win_next;
        stage_byte_reg <= stage_byte_next;
        unit_pos_reg   <= unit_pos_next;
        unit_len_reg   <= unit_len_next;
        unit_esc_reg   <= unit_esc_next;
        out_byte_reg   <= out_byte_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// ===== hdl/uche_classify.sv =====
// byte classifier: utf-8 sequence check and safe character test at one scan position
module uche_classify
(
    input  uche_pkg::win_t      win,
    input  logic [2:0]          wn,
    input  logic [1:0]          pos,
    input  logic                at_end,
    output uche_pkg::decision_t dec
);

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  len;
    logic [2:0]  avail;
    logic        bad;
    logic [20:0] cp;
    logic [20:0] lowest;
    logic        code_ok;
    logic        safe;

    // bytes of the candidate sequence, index wraps where unused
    assign b0 = win[pos];
    assign b1 = win[2'(pos + 2'd1)];
    assign b2 = win[2'(pos + 2'd2)];
    assign b3 = win[2'(pos + 2'd3)];
    assign avail = 3'(wn - {1'b0, pos});

    // length announced by the lead byte
    always_comb
    begin
        if (b0[7] == 1'b0)
            len = 3'd1;
        else if (b0[7:5] == 3'b110)
            len = 3'd2;
        else if (b0[7:4] == 4'b1110)
            len = 3'd3;
        else if (b0[7:3] == 5'b11110)
            len = 3'd4;
        else
            len = 3'd0;
    end

    // continuation bits of the bytes present
    always_comb
    begin
        logic [1:0] idx;
        bad = 1'b0;
        for (int k = 1; k < 4; k++)
        begin
            idx = 2'(pos + 2'(k));
            if (3'(k) < len && 3'(k) < avail && win[idx][7:6] != 2'b10)
                bad = 1'b1;
        end
    end

    // code point and range checks
    always_comb
    begin
        case (len)
            3'd2:
            begin
                cp     = 21'({b0[4:0], b1[5:0]});
                lowest = 21'h80;
            end
            3'd3:
            begin
                cp     = 21'({b0[3:0], b1[5:0], b2[5:0]});
                lowest = 21'h800;
            end
            default:
            begin
                cp     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                lowest = 21'h10000;
            end
        endcase
        code_ok = (cp >= lowest) && (cp < 21'h110000)
                  && (cp[20:11] != 10'h1b)
                  && !(cp >= 21'hfdd0 && cp <= 21'hfdef)
                  && (cp[15:1] != 15'h7fff);
    end

    // letters, digits and the few punctuation marks copied as they are
    always_comb
    begin
        safe = (b0 >= 8'h30 && b0 <= 8'h39) || (b0 >= 8'h41 && b0 <= 8'h5a)
               || (b0 >= 8'h61 && b0 <= 8'h7a)
               || b0 == 8'h23 || b0 == 8'h2b || b0 == 8'h2d || b0 == 8'h2e
               || b0 == 8'h3a || b0 == 8'h3d || b0 == 8'h40 || b0 == 8'h5f;
    end

    // decision
    always_comb
    begin
        dec.avail = avail;
        if (len >= 3'd2 && !bad && avail < len && !at_end)
        begin
            dec.act  = uche_pkg::ACT_HOLD;
            dec.need = 3'd0;
        end
        else if (len >= 3'd2 && !bad && avail >= len && code_ok)
        begin
            dec.act  = uche_pkg::ACT_COPY_SEQ;
            dec.need = len;
        end
        else if (safe)
        begin
            dec.act  = uche_pkg::ACT_COPY_ONE;
            dec.need = 3'd1;
        end
        else
        begin
            dec.act  = uche_pkg::ACT_ESCAPE;
            dec.need = 3'd4;
        end
    end

endmodule

// ===== tb/hex_escape_tb_pkg.sv =====
`timescale 1ns / 100ps
// result type and scoreboard with the escape predictor for the hex escape encoder testbench
package hex_escape_tb_pkg;

    // one result as seen on the result channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last_of_run;
    } esc_result_t;

    class hex_escape_scoreboard;
        // predictor state
        logic [15:0] capacity;
        logic [7:0]  held [3];
        int unsigned held_n;
        logic [7:0]  win [4];
        int unsigned written;
        bit          overflow;

        // results still to arrive, oldest first
        esc_result_t due [$];
        int          errors;
        int          results_seen;

        function new();
            capacity     = uche_pkg::CAP_RESET;
            held_n       = 0;
            written      = 0;
            overflow     = 1'b0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_capacity(logic [15:0] cap);
            capacity = cap;
        endfunction

        function int outstanding();
            return due.size();
        endfunction

        // byte class of a utf-8 lead, 0 for continuation and 5/6-byte leads
        function int unsigned lead_len(logic [7:0] b);
            if (b[7] == 1'b0)
                return 1;
            if (b[7:5] == 3'b110)
                return 2;
            if (b[7:4] == 4'b1110)
                return 3;
            if (b[7:3] == 5'b11110)
                return 4;
            return 0;
        endfunction

        function bit is_safe(logic [7:0] b);
            if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
                (b >= 8'h61 && b <= 8'h7a))
                return 1'b1;
            return b == 8'h23 || b == 8'h2b || b == 8'h2d || b == 8'h2e ||
                   b == 8'h3a || b == 8'h3d || b == 8'h40 || b == 8'h5f;
        endfunction

        function logic [7:0] hex_char(logic [3:0] n);
            return (n < 4'd10) ? 8'h30 + n : 8'h57 + n;
        endfunction

        // decoded code point must be shortest form, in range, not a surrogate and not a noncharacter
        function bit code_valid(int unsigned pos, int unsigned len);
            int unsigned cp;
            int unsigned lowest;
            int unsigned k;
            case (len)
                2:
                begin
                    cp     = win[pos] & 8'h1f;
                    lowest = 32'h80;
                end
                3:
                begin
                    cp     = win[pos] & 8'h0f;
                    lowest = 32'h800;
                end
                default:
                begin
                    cp     = win[pos] & 8'h07;
                    lowest = 32'h10000;
                end
            endcase
            for (k = 1; k < len; k++)
                cp = (cp << 6) | (win[pos + k] & 8'h3f);
            if (cp < lowest)
                return 1'b0;
            if (cp >= 32'h110000)
                return 1'b0;
            if ((cp & 32'hffff_f800) == 32'hd800)
                return 1'b0;
            if (cp >= 32'hfdd0 && cp <= 32'hfdef)
                return 1'b0;
            if ((cp & 32'hfffe) == 32'hfffe)
                return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned room();
            return (capacity > written) ? capacity - written : 0;
        endfunction

        // a unit is written only if it fits whole
        function bit reserve(int unsigned need);
            if (room() < need)
            begin
                overflow = 1'b1;
                return 1'b0;
            end
            written = (written + need) & 32'hffff;
            return 1'b1;
        endfunction

        function void add_result(logic [7:0] b, logic [1:0] kind);
            esc_result_t r;
            r.out_byte    = b;
            r.out_kind    = kind;
            r.last_of_run = 1'b0;
            due.push_back(r);
        endfunction

        // walk the window, copy or escape, hold an unfinished sequence
        function void encode_window(int unsigned n, bit at_end);
            int unsigned pos;
            int unsigned len;
            int unsigned avail;
            int unsigned k;
            bit          bad;
            logic [7:0]  b;
            pos    = 0;
            held_n = 0;
            while (pos < n && !overflow)
            begin
                b     = win[pos];
                len   = lead_len(b);
                avail = n - pos;
                if (len >= 2)
                begin
                    bad = 1'b0;
                    for (k = 1; k < len && k < avail; k++)
                        if (win[pos + k][7:6] != 2'b10)
                            bad = 1'b1;
                    if (!bad && avail < len)
                    begin
                        if (!at_end)
                        begin
                            for (k = 0; k < avail; k++)
                                held[k] = win[pos + k];
                            held_n = avail;
                            return;
                        end
                        bad = 1'b1;
                    end
                    if (!bad && code_valid(pos, len))
                    begin
                        if (!reserve(len))
                            break;
                        for (k = 0; k < len; k++)
                            add_result(win[pos + k], uche_pkg::KIND_DATA);
                        pos += len;
                        continue;
                    end
                end
                if (is_safe(b))
                begin
                    if (!reserve(1))
                        break;
                    add_result(b, uche_pkg::KIND_DATA);
                end
                else
                begin
                    if (!reserve(4))
                        break;
                    add_result(uche_pkg::CHAR_BACKSLASH, uche_pkg::KIND_DATA);
                    add_result(uche_pkg::CHAR_X, uche_pkg::KIND_DATA);
                    add_result(hex_char(b[7:4]), uche_pkg::KIND_DATA);
                    add_result(hex_char(b[3:0]), uche_pkg::KIND_DATA);
                end
                pos++;
            end
            held_n = 0;
        endfunction

        // accepted input byte: predict the results it causes
        function void note_char(logic [7:0] b);
            int unsigned first;
            int unsigned k;
            first = due.size();
            for (k = 0; k < held_n; k++)
                win[k] = held[k];
            if (b != 8'h00)
            begin
                if (!overflow)
                begin
                    win[held_n] = b;
                    encode_window(held_n + 1, 1'b0);
                end
            end
            else
            begin
                if (!overflow)
                begin
                    encode_window(held_n, 1'b1);
                    if (!overflow && room() < 1)
                        overflow = 1'b1;
                end
                add_result(8'h00, overflow ? uche_pkg::KIND_END_OVF : uche_pkg::KIND_END_OK);
                held_n   = 0;
                written  = 0;
                overflow = 1'b0;
            end
            if (due.size() > first)
                due[due.size() - 1].last_of_run = 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
        endtask

        // accepted result: compare with the oldest prediction
        task check_result(esc_result_t got);
            esc_result_t want;
            results_seen++;
            if (due.size() == 0)
            begin
                report($sformatf("unexpected result byte %02h kind %0d last %0d",
                                 got.out_byte, got.out_kind, got.last_of_run));
                return;
            end
            want = due.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, predicted %02h", got.out_byte, want.out_byte));
            if (got.out_kind !== want.out_kind)
                report($sformatf("out_kind %0d, predicted %0d", got.out_kind, want.out_kind));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0d, predicted %0d",
                                 got.last_of_run, want.last_of_run));
        endtask
    endclass

endpackage

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top of the hex escape encoder testbench: clock, reset, stimulus and result handling
module tb_top;

    localparam int RANDOM_ITEMS  = 400;
    localparam int PHASE_ITEMS   = 62;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 2000000;

    logic clk;
    logic rst_n;

    uche_in_if  chars_if ();
    uche_out_if res_if ();
    uche_cfg_if cfg_if ();

    unsafe_char_hex_escaper_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (res_if),
        .cap_wr  (cfg_if)
    );

    hex_escape_tb_pkg::hex_escape_scoreboard sb;

    // bytes queued for sending and bookkeeping of the random part
    logic [7:0] plan [$];
    int         sent;
    bit         quiet;
    int         cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] safe_byte();
        string marks;
        marks = "#+-.:=@_";
        case ($urandom_range(0, 3))
            0: return 8'h30 + 8'($urandom_range(0, 9));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'h61 + 8'($urandom_range(0, 25));
            default: return marks[$urandom_range(0, 7)];
        endcase
    endfunction

    // code point for a sequence of the given length, random or near a boundary
    function automatic logic [20:0] pick_code(int unsigned len);
        logic [20:0] corners [22];
        logic [20:0] mask;
        corners = '{21'h0, 21'h7f, 21'h80, 21'h7ff, 21'h800, 21'hfff, 21'hd7ff, 21'hd800,
                    21'hdfff, 21'he000, 21'hfdcf, 21'hfdd0, 21'hfdef, 21'hfdf0, 21'hfffd,
                    21'hfffe, 21'hffff, 21'h10000, 21'h1fffe, 21'h10ffff, 21'h110000,
                    21'h1fffff};
        mask = (len == 2) ? 21'h7ff : (len == 3) ? 21'hffff : 21'h1fffff;
        if ($urandom_range(0, 1) == 1)
            return 21'($urandom) & mask;
        return corners[$urandom_range(0, 21)] & mask;
    endfunction

    // sequence shapes: whole, cut short, or with a broken continuation byte
    localparam int SEQ_WHOLE = 0;
    localparam int SEQ_CUT   = 1;
    localparam int SEQ_BROKEN = 2;

    function automatic void add_code_seq(int shape);
        int unsigned len;
        int unsigned keep;
        int unsigned k;
        logic [20:0] cp;
        logic [7:0]  seq [4];
        logic [7:0]  b;
        len = $urandom_range(2, 4);
        cp  = pick_code(len);
        case (len)
            2:
            begin
                seq[0] = {3'b110, cp[10:6]};
                seq[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                seq[0] = {4'b1110, cp[15:12]};
                seq[1] = {2'b10, cp[11:6]};
                seq[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                seq[0] = {5'b11110, cp[20:18]};
                seq[1] = {2'b10, cp[17:12]};
                seq[2] = {2'b10, cp[11:6]};
                seq[3] = {2'b10, cp[5:0]};
            end
        endcase
        keep = len;
        if (shape == SEQ_CUT)
            keep = $urandom_range(1, len - 1);
        if (shape == SEQ_BROKEN)
        begin
            b = 8'($urandom_range(1, 255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            seq[$urandom_range(1, len - 1)] = b;
        end
        for (k = 0; k < keep; k++)
            plan.push_back(seq[k]);
    endfunction

    // one random string, mostly utf-8 sequences, ended by a zero byte
    function automatic void build_string();
        int pieces;
        int sel;
        pieces = $urandom_range(0, 12);
        repeat (pieces)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                add_code_seq(SEQ_WHOLE);
            else if (sel < 65)
                plan.push_back(safe_byte());
            else if (sel < 80)
                plan.push_back(8'($urandom_range(1, 255)));
            else if (sel < 90)
                add_code_seq(SEQ_BROKEN);
            else
                add_code_seq(SEQ_CUT);
        end
        plan.push_back(8'h00);
    endfunction

    // one input transaction, valid held high across back-to-back bytes
    task automatic send_char(input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.in_byte <= b;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        sb.note_char(b);
    endtask

    task automatic play_plan();
        while (plan.size() > 0)
        begin
            send_char(plan.pop_front());
            sent++;
        end
    endtask

    // stop sending and let every predicted result arrive
    task automatic wait_idle();
        chars_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        cfg_if.valid           <= 1'b1;
        cfg_if.output_capacity <= cap;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.set_capacity(cap);
        cfg_if.valid <= 1'b0;
    endtask

    // result side: check accepted transactions, stall ready at random
    initial
    begin
        int                            stall;
        hex_escape_tb_pkg::esc_result_t got;
        stall = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                got.out_byte    = res_if.out_byte;
                got.out_kind    = res_if.out_kind;
                got.last_of_run = res_if.last_of_run;
                sb.check_result(got);
            end
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("unsafe_char_hex_escaper_unit test failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int          ph;
        int          target;
        logic [15:0] cap;
        sb    = new();
        sent  = 0;
        quiet = 1'b0;
        rst_n                  <= 1'b0;
        chars_if.valid         <= 1'b0;
        chars_if.in_byte       <= 8'h00;
        cfg_if.valid           <= 1'b0;
        cfg_if.output_capacity <= 16'h0000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // copies, escapes, lone continuation, long lead, truncated sequence at end
        write_capacity(16'hffff);
        plan = '{8'h61, 8'h5c, 8'hff, 8'h80, 8'hfc, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'h00};
        play_plan();
        // four-byte copy, surrogate, delete and lowest control byte
        plan = '{8'hf0, 8'h9f, 8'h98, 8'h80, 8'hed, 8'ha0, 8'h80, 8'h7f, 8'h01, 8'h00};
        play_plan();
        wait_idle();

        // no room left for the terminator, then a unit that does not fit
        write_capacity(16'd5);
        plan = '{8'h61, 8'h01, 8'h00, 8'h02, 8'h62, 8'h63, 8'h00};
        play_plan();
        // capacity lowered below what the open string already used
        plan = '{8'h61, 8'h62, 8'h63};
        play_plan();
        wait_idle();
        write_capacity(16'd0);
        plan = '{8'h00};
        play_plan();
        wait_idle();

        // random strings over several capacity settings
        sent = 0;
        for (ph = 0; sent < RANDOM_ITEMS; ph++)
        begin
            case (ph % 7)
                0: cap = 16'hffff;
                1: cap = 16'd0;
                2: cap = 16'($urandom_range(4, 24));
                3: cap = 16'd1;
                4: cap = 16'($urandom_range(8, 48));
                5: cap = 16'($urandom_range(0, 65535));
                default: cap = 16'hffff;
            endcase
            write_capacity(cap);
            quiet  = (ph % 3 == 2);
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                build_string();
                play_plan();
                if (ph == 0 && $urandom_range(0, 7) == 0)
                    wait_idle();
            end
            wait_idle();
        end
        quiet = 1'b0;

        wait_idle();
        if (sb.errors == 0)
            $display("unsafe_char_hex_escaper_unit test passed");
        else
            $display("unsafe_char_hex_escaper_unit test failed");
        $finish;
    end

endmodule
